### rtl/streaming_top_k_nearest_select_macros.svh
// Assertion macros; clocked on clk, disabled while rst_n is low.
`ifndef STREAMING_TOP_K_NEAREST_SELECT_MACROS_SVH
`define STREAMING_TOP_K_NEAREST_SELECT_MACROS_SVH

`ifndef SYNTH
`define TKNS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`define TKNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TKNS_ASSERT_NEVER(lbl, cond)
`define TKNS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/tkns_pkg.sv
`default_nettype none

package tkns_pkg;

  localparam int LIST_SIZE = 50;
  localparam int DIST_W    = 16;
  localparam int IDX_W     = 16;
  localparam int RANK_W    = 6;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  item_index;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [DIST_W-1:0] best_distance;
    logic [IDX_W-1:0]  best_index;
    logic              slot_valid;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  index;
    logic              filled;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '{distance: '1, index: '0, filled: 1'b0};

  typedef struct packed {
    logic insert;
    logic drain;
  } chain_ctrl_t;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

### rtl/tkns_if.sv
`default_nettype none

interface tkns_in_if;
  logic                valid;
  logic                ready;
  tkns_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tkns_out_if;
  logic                valid;
  logic                ready;
  tkns_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/tkns_cell.sv
`default_nettype none

module tkns_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  tkns_pkg::chain_ctrl_t ctrl,
  input  tkns_pkg::slot_t      cand,
  input  tkns_pkg::slot_t      prev_slot,
  input  wire                  prev_ins,
  input  tkns_pkg::slot_t      next_slot,
  output tkns_pkg::slot_t      slot,
  output logic                 ins
);

  tkns_pkg::slot_t slot_r, slot_nxt;

  // strictly smaller goes in front, so equal distances keep arrival order
  assign ins = !slot_r.filled || (cand.distance < slot_r.distance);

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.drain) begin
      slot_nxt = next_slot;
    end else if (ctrl.insert && ins) begin
      slot_nxt = prev_ins ? prev_slot : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= tkns_pkg::SLOT_EMPTY;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

`default_nettype wire

### rtl/tkns_chain.sv
`default_nettype none

module tkns_chain (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tkns_pkg::chain_ctrl_t ctrl,
  input  tkns_pkg::slot_t       cand,
  output tkns_pkg::slot_t       head
);

  tkns_pkg::slot_t slots [tkns_pkg::LIST_SIZE];
  logic [tkns_pkg::LIST_SIZE-1:0] ins;

  for (genvar k = 0; k < tkns_pkg::LIST_SIZE; k++) begin : g_cell
    tkns_pkg::slot_t prev_s, next_s;
    logic            prev_i;

    if (k == 0) begin : g_first
      assign prev_s = tkns_pkg::SLOT_EMPTY;
      assign prev_i = 1'b0;
    end else begin : g_mid
      assign prev_s = slots[k-1];
      assign prev_i = ins[k-1];
    end

    if (k == tkns_pkg::LIST_SIZE - 1) begin : g_end
      assign next_s = tkns_pkg::SLOT_EMPTY;
    end else begin : g_inner
      assign next_s = slots[k+1];
    end

    tkns_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cand      (cand),
      .prev_slot (prev_s),
      .prev_ins  (prev_i),
      .next_slot (next_s),
      .slot      (slots[k]),
      .ins       (ins[k])
    );
  end

  assign head = slots[0];

endmodule

`default_nettype wire

### rtl/streaming_top_k_nearest_select.sv
// Keeps the LIST_SIZE smallest distances of a query in a row of cells, one
// candidate per cycle: each cell compares the candidate with its own entry
// and takes either the candidate or its left neighbor's entry, so all cells
// update at once whatever the list fill. A candidate with last_item set is
// inserted and then the list shifts out through cell 0, one result per
// output transfer, LIST_SIZE results in rank order with the final one
// flagged; the cells refill with empty slots as they shift. No input is
// taken during that run. Empty slots read as all-ones distance, index 0,
// slot_valid 0.
`default_nettype none

module streaming_top_k_nearest_select (
  input  wire             clk,
  input  wire             rst_n,
  tkns_in_if.sink         in_s,
  tkns_out_if.source      out_s
);

  `include "streaming_top_k_nearest_select_macros.svh"

  tkns_pkg::state_t          state_r, state_nxt;
  logic [tkns_pkg::RANK_W-1:0] rank_r, rank_nxt;
  tkns_pkg::chain_ctrl_t     ctrl;
  tkns_pkg::slot_t           cand, head;
  logic                      in_xfer, out_xfer, last_rank;

  assign in_xfer   = in_s.valid && in_s.ready;
  assign out_xfer  = out_s.valid && out_s.ready;
  assign last_rank = rank_r == tkns_pkg::RANK_W'(tkns_pkg::LIST_SIZE - 1);

  always_comb begin
    state_nxt = state_r;
    rank_nxt  = rank_r;
    case (state_r)
      tkns_pkg::ST_COLLECT: begin
        rank_nxt = '0;
        if (in_xfer && in_s.data.last_item) begin
          state_nxt = tkns_pkg::ST_DRAIN;
        end
      end
      tkns_pkg::ST_DRAIN: begin
        if (out_xfer) begin
          rank_nxt = rank_r + 1'b1;
          if (last_rank) begin
            state_nxt = tkns_pkg::ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = tkns_pkg::ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    in_s.ready  = 1'b0;
    out_s.valid = 1'b0;
    ctrl        = '0;
    case (state_r)
      tkns_pkg::ST_COLLECT: begin
        in_s.ready  = 1'b1;
        ctrl.insert = in_s.valid;
      end
      tkns_pkg::ST_DRAIN: begin
        out_s.valid = 1'b1;
        ctrl.drain  = out_s.ready;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkns_pkg::ST_COLLECT;
      rank_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rank_r  <= rank_nxt;
    end
  end

  assign cand.distance = in_s.data.distance;
  assign cand.index    = in_s.data.item_index;
  assign cand.filled   = 1'b1;

  tkns_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .cand  (cand),
    .head  (head)
  );

  assign out_s.data.rank          = rank_r;
  assign out_s.data.best_distance = head.distance;
  assign out_s.data.best_index    = head.index;
  assign out_s.data.slot_valid    = head.filled;
  assign out_s.data.last_result   = last_rank;

  `TKNS_ASSERT_NEVER(a_no_overlap, in_s.ready && out_s.valid)
  `TKNS_ASSERT_NEXT(a_flush_starts, in_xfer && in_s.data.last_item,
                    out_s.valid && (rank_r == '0))
  `TKNS_ASSERT_NEXT(a_flush_ends, out_xfer && out_s.data.last_result,
                    in_s.ready && !out_s.valid)
  `TKNS_ASSERT_NEXT(a_rank_steps, out_xfer && !out_s.data.last_result,
                    out_s.valid && (rank_r == $past(rank_r) + 1'b1))

endmodule

`default_nettype wire
